FILE: rtl/ttb_pkg.sv
// Package for the triangle tangent and bitangent block.
// Holds the vertex, delta and result types shared by the front, back, emit and top level.
// No dependencies.
`timescale 1ns / 1ps

package ttb_pkg;

   localparam int unsigned CW = 32;
   localparam int unsigned FB = 16;
   localparam int unsigned DW = CW + 1;
   localparam int unsigned PW = 2 * DW + 1;
   localparam int unsigned NW = PW + FB;

   typedef struct packed {
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic signed [CW-1:0] pos_z;
      logic signed [CW-1:0] tex_u;
      logic signed [CW-1:0] tex_v;
   } vertex_type;

   typedef struct packed {
      logic signed [DW-1:0] dp1_x;
      logic signed [DW-1:0] dp1_y;
      logic signed [DW-1:0] dp1_z;
      logic signed [DW-1:0] dp2_x;
      logic signed [DW-1:0] dp2_y;
      logic signed [DW-1:0] dp2_z;
      logic signed [DW-1:0] du1;
      logic signed [DW-1:0] dv1;
      logic signed [DW-1:0] du2;
      logic signed [DW-1:0] dv2;
   } delta_type;

   typedef struct packed {
      logic [CW-1:0] tangent_x;
      logic [CW-1:0] tangent_y;
      logic [CW-1:0] tangent_z;
      logic [CW-1:0] bitangent_x;
      logic [CW-1:0] bitangent_y;
      logic [CW-1:0] bitangent_z;
      logic          degenerate;
   } basis_type;

endpackage

FILE: rtl/ttb_front.sv
// Front end: accepts vertices, holds the first two corners of a triangle and
// forms the edge and texture deltas on the third. Depends on ttb_pkg.
`timescale 1ns / 1ps

module ttb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ttb_pkg::vertex_type in_vertex,
   output logic                dq_valid,
   input  logic                dq_ready,
   output ttb_pkg::delta_type  dq_delta
);
   import ttb_pkg::*;

   vertex_type v0_ff, v1_ff, v0_in, v1_in;
   logic [1:0] count_ff, count_in;
   delta_type  delta_ff, delta_in;
   logic       valid_ff, valid_in;

   assign in_ready = !valid_ff || dq_ready;
   assign dq_valid = valid_ff;
   assign dq_delta = delta_ff;

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      count_in = count_ff;
      delta_in = delta_ff;
      valid_in = valid_ff && !dq_ready;
      if (in_valid && in_ready) begin
         if (count_ff == 2'd0) begin
            v0_in = in_vertex;
            count_in = 2'd1;
         end else if (count_ff == 2'd1) begin
            v1_in = in_vertex;
            count_in = 2'd2;
         end else begin
            count_in = 2'd0;
            valid_in = 1'b1;
            delta_in.dp1_x = DW'(v1_ff.pos_x) - DW'(v0_ff.pos_x);
            delta_in.dp1_y = DW'(v1_ff.pos_y) - DW'(v0_ff.pos_y);
            delta_in.dp1_z = DW'(v1_ff.pos_z) - DW'(v0_ff.pos_z);
            delta_in.dp2_x = DW'(in_vertex.pos_x) - DW'(v0_ff.pos_x);
            delta_in.dp2_y = DW'(in_vertex.pos_y) - DW'(v0_ff.pos_y);
            delta_in.dp2_z = DW'(in_vertex.pos_z) - DW'(v0_ff.pos_z);
            delta_in.du1 = DW'(v1_ff.tex_u) - DW'(v0_ff.tex_u);
            delta_in.dv1 = DW'(v1_ff.tex_v) - DW'(v0_ff.tex_v);
            delta_in.du2 = DW'(in_vertex.tex_u) - DW'(v0_ff.tex_u);
            delta_in.dv2 = DW'(in_vertex.tex_v) - DW'(v0_ff.tex_v);
         end
      end
   end

   always_ff @(posedge clock) begin
      v0_ff <= v0_in;
      v1_ff <= v1_in;
      delta_ff <= delta_in;
      if (reset) begin
         count_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: rtl/ttb_back.sv
// Back end: forms the determinant and six numerators with one shared
// multiplier, then divides each by a shared restoring divider. Depends on ttb_pkg.
`timescale 1ns / 1ps

module ttb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                dq_valid,
   output logic                dq_ready,
   input  ttb_pkg::delta_type  dq_delta,
   output logic                res_valid,
   input  logic                res_ready,
   output ttb_pkg::basis_type  res_basis
);
   import ttb_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_type;

   state_type state_ff;
   delta_type d_ff;
   logic [3:0] step_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [PW-1:0] det_ff;
   logic signed [PW-1:0] num_ff [6];
   logic [2:0] idx_ff;
   logic [$clog2(NW+1)-1:0] bit_ff;
   logic [NW-1:0] n_ff, q_ff;
   logic [PW-1:0] r_ff;
   logic [PW-1:0] dmag_ff;
   logic neg_ff;
   logic [CW-1:0] out_ff [6];
   logic degen_ff;

   logic signed [DW-1:0] ma, mb;
   logic signed [PW-1:0] mprod;
   logic [PW:0] r_sh;
   logic [NW-1:0] q_sh;
   logic [CW-1:0] sat_val;
   logic signed [PW-1:0] cur_num;
   logic [NW-1:0] lim;

   always_comb begin
      unique case (step_ff)
         4'd0: begin ma = d_ff.du1; mb = d_ff.dv2; end
         4'd1: begin ma = d_ff.dv1; mb = d_ff.du2; end
         4'd2: begin ma = d_ff.dp1_x; mb = d_ff.dv2; end
         4'd3: begin ma = d_ff.dp2_x; mb = d_ff.dv1; end
         4'd4: begin ma = d_ff.dp1_y; mb = d_ff.dv2; end
         4'd5: begin ma = d_ff.dp2_y; mb = d_ff.dv1; end
         4'd6: begin ma = d_ff.dp1_z; mb = d_ff.dv2; end
         4'd7: begin ma = d_ff.dp2_z; mb = d_ff.dv1; end
         4'd8: begin ma = d_ff.dp2_x; mb = d_ff.du1; end
         4'd9: begin ma = d_ff.dp1_x; mb = d_ff.du2; end
         4'd10: begin ma = d_ff.dp2_y; mb = d_ff.du1; end
         4'd11: begin ma = d_ff.dp1_y; mb = d_ff.du2; end
         4'd12: begin ma = d_ff.dp2_z; mb = d_ff.du1; end
         default: begin ma = d_ff.dp1_z; mb = d_ff.du2; end
      endcase
      mprod = PW'(ma) * PW'(mb);
      r_sh = {r_ff, n_ff[NW-1]};
      q_sh = {q_ff[NW-2:0], 1'b0};
      cur_num = num_ff[idx_ff];
      lim = NW'(1) << (CW - 1);
      if (neg_ff)
         sat_val = (q_ff > lim) ? CW'(lim) : CW'(-q_ff);
      else
         sat_val = (q_ff >= lim) ? CW'(lim - 1'b1) : CW'(q_ff);
   end

   assign dq_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_basis.tangent_x = out_ff[0];
   assign res_basis.tangent_y = out_ff[1];
   assign res_basis.tangent_z = out_ff[2];
   assign res_basis.bitangent_x = out_ff[3];
   assign res_basis.bitangent_y = out_ff[4];
   assign res_basis.bitangent_z = out_ff[5];
   assign res_basis.degenerate = degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (dq_valid) begin
                  d_ff <= dq_delta;
                  step_ff <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= mprod;
               step_ff <= step_ff + 4'd1;
               if (step_ff[0]) begin
                  if (step_ff == 4'd1) det_ff <= prod_ff - mprod;
                  else num_ff[3'((step_ff - 4'd2) >> 1)] <= prod_ff - mprod;
               end
               if (step_ff == 4'd13) begin
                  idx_ff <= '0;
                  bit_ff <= '0;
                  state_ff <= ST_DIV;
                  degen_ff <= (det_ff == '0);
               end
            end
            ST_DIV: begin
               if (bit_ff == '0) begin
                  n_ff <= NW'(cur_num[PW-1] ? -cur_num : cur_num) << FB;
                  dmag_ff <= det_ff[PW-1] ? -det_ff : det_ff;
                  neg_ff <= cur_num[PW-1] ^ det_ff[PW-1];
                  r_ff <= '0;
                  q_ff <= '0;
                  bit_ff <= bit_ff + 1'b1;
               end else if (bit_ff <= NW) begin
                  n_ff <= n_ff << 1;
                  if (r_sh >= {1'b0, dmag_ff}) begin
                     r_ff <= PW'(r_sh - {1'b0, dmag_ff});
                     q_ff <= q_sh | NW'(1);
                  end else begin
                     r_ff <= r_sh[PW-1:0];
                     q_ff <= q_sh;
                  end
                  bit_ff <= bit_ff + 1'b1;
               end else begin
                  out_ff[idx_ff] <= degen_ff ? '0 : sat_val;
                  bit_ff <= '0;
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd5) state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (res_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/ttb_emit.sv
// Result stage: sends one computed basis as three beats, one per corner.
// Depends on ttb_pkg.
`timescale 1ns / 1ps

module ttb_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               res_valid,
   output logic               res_ready,
   input  ttb_pkg::basis_type res_basis,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [1:0]         out_corner,
   output logic               out_last,
   output ttb_pkg::basis_type out_basis
);
   import ttb_pkg::*;

   logic [1:0] corner_ff;
   logic       busy_ff;
   basis_type  basis_ff;

   assign res_ready = !busy_ff;
   assign out_valid = busy_ff;
   assign out_corner = corner_ff;
   assign out_last = (corner_ff == 2'd2);
   assign out_basis = basis_ff;

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) basis_ff <= res_basis;
      if (reset) begin
         busy_ff <= 1'b0;
         corner_ff <= '0;
      end else if (res_valid && res_ready) begin
         busy_ff <= 1'b1;
         corner_ff <= '0;
      end else if (busy_ff && out_ready) begin
         if (corner_ff == 2'd2) busy_ff <= 1'b0;
         corner_ff <= corner_ff + 2'd1;
      end
   end

endmodule

FILE: rtl/triangle_tangent_bitangent.sv
// Top level of the triangle tangent and bitangent block.
// Depends on ttb_pkg, ttb_front, ttb_back and ttb_emit.
`timescale 1ns / 1ps

// Vertices arrive as beats on the req_ stream, three per triangle. The first
// two are held; the third completes the triangle and yields three result
// beats on the rsp_ stream, corner 0, 1 and 2, with tlast on corner 2.
// The front stage forms the deltas and hands them to the back
// stage through a one-entry queue, so the next triangle's corners are taken
// while the back stage still works.
// The back stage forms the determinant and numerator products in turn on the
// shared multiplier and then the six quotients on the shared bit-serial
// divider; it takes no new triangle until its last result is taken, and the
// divider sets the throughput.
// Reset discards any held corners and empties every stage. When the receiver
// stalls the result beat holds and the stages fill and then stop accepting.
module triangle_tangent_bitangent (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [159:0]  req_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [199:0]  rsp_tdata,   // corner, tangent_x/y/z, bitangent_x/y/z, zeros
   output logic          rsp_tuser,   // degenerate
   output logic          rsp_tlast
);
   import ttb_pkg::*;

   vertex_type vtx;
   delta_type  dq_delta;
   basis_type  res_basis, out_basis;
   logic dq_valid, dq_ready, res_valid, res_ready;
   logic [1:0] out_corner;

   assign vtx.pos_x = req_tdata[31:0];
   assign vtx.pos_y = req_tdata[63:32];
   assign vtx.pos_z = req_tdata[95:64];
   assign vtx.tex_u = req_tdata[127:96];
   assign vtx.tex_v = req_tdata[159:128];

   ttb_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_vertex(vtx),
      .dq_valid, .dq_ready, .dq_delta
   );

   ttb_back u_back (
      .clock, .reset,
      .dq_valid, .dq_ready, .dq_delta,
      .res_valid, .res_ready, .res_basis
   );

   ttb_emit u_emit (
      .clock, .reset,
      .res_valid, .res_ready, .res_basis,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_corner, .out_last(rsp_tlast), .out_basis
   );

   assign rsp_tdata = {6'd0, out_basis.bitangent_z, out_basis.bitangent_y,
                       out_basis.bitangent_x, out_basis.tangent_z,
                       out_basis.tangent_y, out_basis.tangent_x, out_corner};
   assign rsp_tuser = out_basis.degenerate;

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (out_corner == 2'd2)))
      else $error("tlast does not match corner");

   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_corner != 2'd3))
      else $error("corner out of range");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[193:2] == '0))
      else $error("degenerate result carries non-zero vectors");

endmodule
